// ===== design/wfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// WebSocket frame decoder package
// Shared types and constants for the frame decoder: the input and result
// payload structs, the decode phase and the status codes.
// ----------------------------------------------------------------------------
package wfd_pkg;

  // Default chunk size in bytes.
  localparam int CHUNK_BYTES_DEF = 4096;

  // Width of the received byte counter and its largest value.
  localparam int SEEN_W   = 12;
  localparam int SEEN_MAX = 4095;

  // A chunk shorter than this many bytes is reported as too short.
  localparam int MIN_FRAME_BYTES = 6;

  // Depth of the result queue and its pointer width.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  // Header field masks and the extended length codes.
  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [7:0] OPCODE_MASK = 8'h0f;
  localparam logic [7:0] LEN_MASK    = 8'h7f;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;

  // Decode phase within one chunk.
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_KEY0    = 3'd2,
    PH_KEY1    = 3'd3,
    PH_KEY2    = 3'd4,
    PH_KEY3    = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_IGNORE  = 3'd7
  } phase_t;

  // Frame status reported on the last byte of a chunk.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_SHORT  = 2'd1,
    ST_EXT_LENGTH = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_t;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // One received byte.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       chunk_end;
  } item_t;

  // One result.
  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       fin_bit;
    logic [3:0] frame_opcode;
    logic [1:0] frame_status;
    logic [6:0] payload_len;
    logic       last_of_run;
  } result_t;

endpackage
`default_nettype wire

// ===== design/websocket_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A result is written into the result queue on the transfer of the byte that causes it.
// Throughput: one byte per cycle while results drain; a chunk-ending byte that is also a
// payload byte yields two results, which the queue absorbs; only result stalls slow input.
// The input is ready while at least two of the four result queue slots are free.
// Reset (synchronous, active high) clears the frame state and empties the result queue.
// ----------------------------------------------------------------------------
// WebSocket frame decoder
// Decodes the base header of one received chunk byte by byte, unmasks the
// payload bytes and reports a frame status on the last byte of the chunk.
// ----------------------------------------------------------------------------
module websocket_frame_decoder #(
  parameter int CHUNK_BYTES = wfd_pkg::CHUNK_BYTES_DEF
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   item_valid,
  output logic                  item_ready,
  input  wire wfd_pkg::item_t   item,
  output logic                  result_valid,
  input  wire                   result_ready,
  output wfd_pkg::result_t      result
);

  // Saturation value of the received byte counter.
  localparam logic [wfd_pkg::SEEN_W-1:0] SEEN_CAP =
    ((CHUNK_BYTES - 1) < wfd_pkg::SEEN_MAX) ?
    wfd_pkg::SEEN_W'(CHUNK_BYTES - 1) : wfd_pkg::SEEN_W'(wfd_pkg::SEEN_MAX);
  localparam logic [wfd_pkg::SEEN_W-1:0] SHORT_LIMIT =
    wfd_pkg::SEEN_W'(wfd_pkg::MIN_FRAME_BYTES - 1);

  // Frame state.
  wfd_pkg::phase_t             phase, phase_next;
  logic                        fin_flag, fin_flag_next;
  logic [3:0]                  opcode_reg, opcode_reg_next;
  logic                        masked_flag, masked_flag_next;
  logic [6:0]                  length_reg, length_reg_next;
  logic [31:0]                 mask_key, mask_key_next;
  logic [6:0]                  payload_count, payload_count_next;
  logic [wfd_pkg::SEEN_W-1:0]  bytes_seen, bytes_seen_next;

  // Result queue.
  wfd_pkg::result_t            res_q [wfd_pkg::RES_DEPTH];
  logic [wfd_pkg::RES_PTR_W-1:0] head, tail;
  logic [wfd_pkg::RES_CNT_W-1:0] count;

  // Decode outputs for the current byte.
  logic             item_fire, result_fire;
  logic             have_payload;
  logic [7:0]       pbyte, key_byte;
  wfd_pkg::status_t status;
  wfd_pkg::result_t res_first, res_second;
  logic [1:0]       n_results;

  // Working values before the end-of-chunk clear.
  wfd_pkg::phase_t  phase_upd;
  logic             fin_upd, masked_upd;
  logic [3:0]       opcode_upd;
  logic [6:0]       length_upd, pcount_upd;
  logic [31:0]      key_upd;

  assign item_fire    = item_valid && item_ready;
  assign result_fire  = result_valid && result_ready;
  assign item_ready   = (count <= wfd_pkg::RES_CNT_W'(wfd_pkg::RES_DEPTH - 2));
  assign result_valid = (count != '0);
  assign result       = res_q[head];

  // Header decode, key capture and payload unmasking.
  always_comb begin
    phase_upd    = phase;
    fin_upd      = fin_flag;
    opcode_upd   = opcode_reg;
    masked_upd   = masked_flag;
    length_upd   = length_reg;
    key_upd      = mask_key;
    pcount_upd   = payload_count;
    have_payload = 1'b0;
    pbyte        = '0;
    key_byte     = '0;

    case (phase)
      wfd_pkg::PH_HDR0: begin
        fin_upd    = |(item.data_byte & wfd_pkg::FIN_MASK);
        opcode_upd = 4'(item.data_byte & wfd_pkg::OPCODE_MASK);
        phase_upd  = wfd_pkg::PH_HDR1;
      end
      wfd_pkg::PH_HDR1: begin
        masked_upd = |(item.data_byte & wfd_pkg::FIN_MASK);
        length_upd = 7'(item.data_byte & wfd_pkg::LEN_MASK);
        if (length_upd == wfd_pkg::LEN_EXT16 || length_upd == wfd_pkg::LEN_EXT64) begin
          phase_upd = wfd_pkg::PH_IGNORE;
        end else if (masked_upd) begin
          phase_upd = wfd_pkg::PH_KEY0;
        end else begin
          phase_upd = wfd_pkg::PH_PAYLOAD;
        end
      end
      wfd_pkg::PH_KEY0: begin
        key_upd[31:24] = item.data_byte;
        phase_upd      = wfd_pkg::PH_KEY1;
      end
      wfd_pkg::PH_KEY1: begin
        key_upd[23:16] = item.data_byte;
        phase_upd      = wfd_pkg::PH_KEY2;
      end
      wfd_pkg::PH_KEY2: begin
        key_upd[15:8] = item.data_byte;
        phase_upd     = wfd_pkg::PH_KEY3;
      end
      wfd_pkg::PH_KEY3: begin
        key_upd[7:0] = item.data_byte;
        phase_upd    = wfd_pkg::PH_PAYLOAD;
      end
      wfd_pkg::PH_PAYLOAD: begin
        if (payload_count < length_reg) begin
          case (payload_count[1:0])
            2'd0:    key_byte = mask_key[31:24];
            2'd1:    key_byte = mask_key[23:16];
            2'd2:    key_byte = mask_key[15:8];
            default: key_byte = mask_key[7:0];
          endcase
          pbyte        = masked_flag ? (item.data_byte ^ key_byte) : item.data_byte;
          have_payload = 1'b1;
          pcount_upd   = payload_count + 7'd1;
        end
      end
      default: begin
      end
    endcase

    // Status from the updated header and payload count.
    if (bytes_seen < SHORT_LIMIT) begin
      status = wfd_pkg::ST_TOO_SHORT;
    end else if (length_upd == wfd_pkg::LEN_EXT16 || length_upd == wfd_pkg::LEN_EXT64) begin
      status = wfd_pkg::ST_EXT_LENGTH;
    end else if (pcount_upd < length_upd) begin
      status = wfd_pkg::ST_INCOMPLETE;
    end else begin
      status = wfd_pkg::ST_OK;
    end

    // Result words.
    res_second.kind         = wfd_pkg::KIND_STATUS;
    res_second.payload_byte = '0;
    res_second.fin_bit      = fin_upd;
    res_second.frame_opcode = opcode_upd;
    res_second.frame_status = status;
    res_second.payload_len  = length_upd;
    res_second.last_of_run  = 1'b1;

    if (have_payload) begin
      res_first.kind         = wfd_pkg::KIND_PAYLOAD;
      res_first.payload_byte = pbyte;
      res_first.fin_bit      = fin_upd;
      res_first.frame_opcode = opcode_upd;
      res_first.frame_status = wfd_pkg::ST_OK;
      res_first.payload_len  = length_upd;
      res_first.last_of_run  = !item.chunk_end;
    end else begin
      res_first = res_second;
    end
    n_results = {1'b0, have_payload} + {1'b0, item.chunk_end};

    // Next state; the end of a chunk clears the whole frame.
    if (item.chunk_end) begin
      phase_next         = wfd_pkg::PH_HDR0;
      fin_flag_next      = 1'b0;
      opcode_reg_next    = '0;
      masked_flag_next   = 1'b0;
      length_reg_next    = '0;
      mask_key_next      = '0;
      payload_count_next = '0;
      bytes_seen_next    = '0;
    end else begin
      phase_next         = phase_upd;
      fin_flag_next      = fin_upd;
      opcode_reg_next    = opcode_upd;
      masked_flag_next   = masked_upd;
      length_reg_next    = length_upd;
      mask_key_next      = key_upd;
      payload_count_next = pcount_upd;
      bytes_seen_next    = (bytes_seen < SEEN_CAP) ? bytes_seen + 1'b1 : bytes_seen;
    end
  end

  // Frame state registers, updated on each input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wfd_pkg::PH_HDR0;
      fin_flag      <= 1'b0;
      opcode_reg    <= '0;
      masked_flag   <= 1'b0;
      length_reg    <= '0;
      mask_key      <= '0;
      payload_count <= '0;
      bytes_seen    <= '0;
    end else if (item_fire) begin
      phase         <= phase_next;
      fin_flag      <= fin_flag_next;
      opcode_reg    <= opcode_reg_next;
      masked_flag   <= masked_flag_next;
      length_reg    <= length_reg_next;
      mask_key      <= mask_key_next;
      payload_count <= payload_count_next;
      bytes_seen    <= bytes_seen_next;
    end
  end

  // Result queue storage: up to two writes per input transfer.
  always_ff @(posedge clk) begin
    if (item_fire && n_results != 2'd0) begin
      res_q[tail] <= res_first;
    end
    if (item_fire && n_results == 2'd2) begin
      res_q[tail + 1'b1] <= res_second;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (result_fire) begin
        head <= head + 1'b1;
      end
      if (item_fire) begin
        tail <= tail + wfd_pkg::RES_PTR_W'(n_results);
      end
      count <= count + (item_fire ? wfd_pkg::RES_CNT_W'(n_results) : '0)
                     - wfd_pkg::RES_CNT_W'(result_fire);
    end
  end

  // The queue never holds more results than it has slots.
  assert property (@(posedge clk) disable iff (rst)
    count <= wfd_pkg::RES_CNT_W'(wfd_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // The emitted payload count never passes the stated length.
  assert property (@(posedge clk) disable iff (rst)
    payload_count <= length_reg)
    else $error("payload count exceeds stated length");

  // A byte that ends a chunk leaves the decoder at header byte zero.
  assert property (@(posedge clk) disable iff (rst)
    item_fire && item.chunk_end |=> phase == wfd_pkg::PH_HDR0 && bytes_seen == '0)
    else $error("frame state not cleared at chunk end");

  // A status result always closes the run of its byte.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == wfd_pkg::KIND_STATUS |-> result.last_of_run)
    else $error("status result not last of run");

  // The byte counter stays within its saturation value.
  assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= SEEN_CAP)
    else $error("byte counter past saturation");

endmodule
`default_nettype wire
